// ----- rtl/cv2d_pkg.sv -----
// Shared types, codes and default sizes for the multi-map 2D convolution block.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package cv2d_pkg;

   localparam int DEF_MAX_DIM      = 64;
   localparam int DEF_MAX_KERNEL   = 8;
   localparam int DEF_MAX_IN_MAPS  = 8;
   localparam int DEF_MAX_OUT_MAPS = 8;

   localparam int SUM_W = 48;

   localparam logic [1:0] FUNC_WR_WGT  = 2'd0;
   localparam logic [1:0] FUNC_WR_PIX  = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [1:0] KIND_WR_WGT  = 2'd0;
   localparam logic [1:0] KIND_WR_PIX  = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [2:0] REG_IN_WIDTH      = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd2;
   localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_IN_MAPS       = 3'd4;
   localparam logic [2:0] REG_OUT_MAPS      = 3'd5;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         src_map;
      logic [2:0]         dst_map;
      logic [5:0]         col;
      logic [5:0]         row;
      logic signed [15:0] sample;
   } cmd_type;

   typedef struct packed {
      logic [6:0] in_width;
      logic [6:0] in_height;
      logic [3:0] kernel_width;
      logic [3:0] kernel_height;
      logic [3:0] in_maps;
      logic [3:0] out_maps;
   } cfg_type;

endpackage

// ----- rtl/conv2d_forward_multi_map.sv -----
// Top level of the valid-mode multi-map 2D convolution block.
// Depends on cv2d_pkg, cv2d_front, cv2d_queue and cv2d_back.
//
//   Channel   Direction  Handshake        Payload
//   req_      in         push / full      func, src_map, dst_map, col, row, sample
//   rsp_      out        empty / pop      conv_sum, status
//   csr_      in         valid / ready    index, data
//
// Writes and rejected requests complete in the idle state of the compute engine. A
// compute transaction feeds every kernel tap of every input map through memory
// read, multiply and accumulate on the single multiply-accumulate unit, then
// drains; the engine handles one transaction at a time.
// Reset is synchronous and active high; it restores the register defaults and
// empties both queues. Memories are not cleared: their contents are undefined
// until written. The command queue lets requests enter while the engine works,
// and the result queue lets the engine finish while the consumer stalls.
module conv2d_forward_multi_map #(
   parameter int MAX_DIM      = cv2d_pkg::DEF_MAX_DIM,
   parameter int MAX_KERNEL   = cv2d_pkg::DEF_MAX_KERNEL,
   parameter int MAX_IN_MAPS  = cv2d_pkg::DEF_MAX_IN_MAPS,
   parameter int MAX_OUT_MAPS = cv2d_pkg::DEF_MAX_OUT_MAPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [1:0]                        req_func,
   input  logic [2:0]                        req_src_map,
   input  logic [2:0]                        req_dst_map,
   input  logic [5:0]                        req_col,
   input  logic [5:0]                        req_row,
   input  logic signed [15:0]                req_sample,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [cv2d_pkg::SUM_W-1:0] rsp_conv_sum,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [6:0]                        csr_data
);

   cv2d_pkg::cmd_type front_cmd, head_cmd;
   cv2d_pkg::cfg_type cfg;
   logic              q_valid, q_pop;

   // The front end classifies each request against the live register values.
   cv2d_front #(
      .MAX_DIM(MAX_DIM), .MAX_KERNEL(MAX_KERNEL),
      .MAX_IN_MAPS(MAX_IN_MAPS), .MAX_OUT_MAPS(MAX_OUT_MAPS)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .func(req_func), .src_map(req_src_map), .dst_map(req_dst_map),
      .col(req_col), .row(req_row), .sample(req_sample),
      .cmd(front_cmd), .cfg(cfg)
   );

   // Short queue decoupling acceptance from execution.
   cv2d_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_cmd(front_cmd), .full(full),
      .pop(q_pop), .valid(q_valid), .head_cmd(head_cmd)
   );

   // The engine owns both memories and the result queue.
   cv2d_back #(
      .MAX_DIM(MAX_DIM), .MAX_KERNEL(MAX_KERNEL),
      .MAX_IN_MAPS(MAX_IN_MAPS), .MAX_OUT_MAPS(MAX_OUT_MAPS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_valid(q_valid), .q_cmd(head_cmd), .q_pop(q_pop),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_conv_sum(rsp_conv_sum), .rsp_status(rsp_status)
   );

endmodule

// ----- rtl/cv2d_queue.sv -----
// Two-entry command queue between the front end and the compute engine.
// Depends on cv2d_pkg for the command type.
module cv2d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cv2d_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output cv2d_pkg::cmd_type head_cmd
);

   cv2d_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/cv2d_front.sv -----
// Front end: configuration registers and classification of incoming requests.
// Depends on cv2d_pkg for codes and the command and configuration types.
module cv2d_front #(
   parameter int MAX_DIM      = cv2d_pkg::DEF_MAX_DIM,
   parameter int MAX_KERNEL   = cv2d_pkg::DEF_MAX_KERNEL,
   parameter int MAX_IN_MAPS  = cv2d_pkg::DEF_MAX_IN_MAPS,
   parameter int MAX_OUT_MAPS = cv2d_pkg::DEF_MAX_OUT_MAPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_data,
   input  logic [1:0]        func,
   input  logic [2:0]        src_map,
   input  logic [2:0]        dst_map,
   input  logic [5:0]        col,
   input  logic [5:0]        row,
   input  logic signed [15:0] sample,
   output cv2d_pkg::cmd_type cmd,
   output cv2d_pkg::cfg_type cfg
);

   localparam logic [6:0] RST_DIM    = (MAX_DIM < 64) ? 7'(MAX_DIM) : 7'd64;
   localparam logic [3:0] RST_KERNEL = (MAX_KERNEL < 5) ? 4'(MAX_KERNEL) : 4'd5;

   cv2d_pkg::cfg_type cfg_ff, cfg_in;
   logic              wgt_ok, pix_ok, cmp_ok;

   function automatic logic [6:0] clamp7(input logic [6:0] v, input int hi);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) r = 7'd1;
      else if (32'(v) > 32'(hi)) r = 7'(hi);
      return r;
   endfunction

   function automatic logic [3:0] clamp4(input logic [3:0] v, input int hi);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (32'(v) > 32'(hi)) r = 4'(hi);
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cv2d_pkg::REG_IN_WIDTH:
               cfg_in.in_width = clamp7(csr_data, MAX_DIM);
            cv2d_pkg::REG_IN_HEIGHT:
               cfg_in.in_height = clamp7(csr_data, MAX_DIM);
            cv2d_pkg::REG_KERNEL_WIDTH:
               cfg_in.kernel_width = clamp4(csr_data[3:0], MAX_KERNEL);
            cv2d_pkg::REG_KERNEL_HEIGHT:
               cfg_in.kernel_height = clamp4(csr_data[3:0], MAX_KERNEL);
            cv2d_pkg::REG_IN_MAPS:
               cfg_in.in_maps = clamp4(csr_data[3:0], MAX_IN_MAPS);
            cv2d_pkg::REG_OUT_MAPS:
               cfg_in.out_maps = clamp4(csr_data[3:0], MAX_OUT_MAPS);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width      <= RST_DIM;
         cfg_ff.in_height     <= RST_DIM;
         cfg_ff.kernel_width  <= RST_KERNEL;
         cfg_ff.kernel_height <= RST_KERNEL;
         cfg_ff.in_maps       <= 4'd1;
         cfg_ff.out_maps      <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Range checks; the kernel may be wider than the map, which fails the compute check.
   always_comb begin
      wgt_ok = ({1'b0, src_map} < cfg_ff.in_maps) && ({1'b0, dst_map} < cfg_ff.out_maps)
               && ({1'b0, col} < {3'b0, cfg_ff.kernel_width})
               && ({1'b0, row} < {3'b0, cfg_ff.kernel_height});
      pix_ok = ({1'b0, src_map} < cfg_ff.in_maps) && ({1'b0, col} < cfg_ff.in_width)
               && ({1'b0, row} < cfg_ff.in_height);
      cmp_ok = ({1'b0, dst_map} < cfg_ff.out_maps)
               && ({2'b0, col} + {4'b0, cfg_ff.kernel_width} <= {1'b0, cfg_ff.in_width})
               && ({2'b0, row} + {4'b0, cfg_ff.kernel_height} <= {1'b0, cfg_ff.in_height});
      cmd.src_map = src_map;
      cmd.dst_map = dst_map;
      cmd.col     = col;
      cmd.row     = row;
      cmd.sample  = sample;
      unique case (func)
         cv2d_pkg::FUNC_WR_WGT:
            cmd.kind = wgt_ok ? cv2d_pkg::KIND_WR_WGT : cv2d_pkg::KIND_ERROR;
         cv2d_pkg::FUNC_WR_PIX:
            cmd.kind = pix_ok ? cv2d_pkg::KIND_WR_PIX : cv2d_pkg::KIND_ERROR;
         cv2d_pkg::FUNC_COMPUTE:
            cmd.kind = cmp_ok ? cv2d_pkg::KIND_COMPUTE : cv2d_pkg::KIND_ERROR;
         default: cmd.kind = cv2d_pkg::KIND_ERROR;
      endcase
   end

endmodule

// ----- rtl/cv2d_back.sv -----
// Back end: pixel and weight memories, the multiply-accumulate engine and the
// two-entry result queue. Depends on cv2d_pkg.
module cv2d_back #(
   parameter int MAX_DIM      = cv2d_pkg::DEF_MAX_DIM,
   parameter int MAX_KERNEL   = cv2d_pkg::DEF_MAX_KERNEL,
   parameter int MAX_IN_MAPS  = cv2d_pkg::DEF_MAX_IN_MAPS,
   parameter int MAX_OUT_MAPS = cv2d_pkg::DEF_MAX_OUT_MAPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cv2d_pkg::cfg_type                cfg,
   input  logic                             q_valid,
   input  cv2d_pkg::cmd_type                q_cmd,
   output logic                             q_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic signed [cv2d_pkg::SUM_W-1:0] rsp_conv_sum,
   output logic                             rsp_status
);

   localparam int PIX_DEPTH = MAX_IN_MAPS * MAX_DIM * MAX_DIM;
   localparam int WGT_DEPTH = MAX_OUT_MAPS * MAX_IN_MAPS * MAX_KERNEL * MAX_KERNEL;
   localparam int PAW = $clog2(PIX_DEPTH);
   localparam int WAW = $clog2(WGT_DEPTH);
   localparam int MW  = (MAX_IN_MAPS > 1) ? $clog2(MAX_IN_MAPS) : 1;
   localparam int KW  = $clog2(MAX_KERNEL);
   localparam int SW  = cv2d_pkg::SUM_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic signed [15:0] pix_mem [PIX_DEPTH];
   logic signed [15:0] wgt_mem [WGT_DEPTH];

   logic [1:0]        state_ff, state_in;
   cv2d_pkg::cmd_type job_ff, job_in;
   logic [MW-1:0]     m_ff, m_in;
   logic [KW-1:0]     u_ff, u_in, v_ff, v_in;
   logic              s1_ff, s1_in, last1_ff, last1_in;
   logic              s2_ff, last2_ff;
   logic signed [15:0] p_rd_ff, w_rd_ff;
   logic signed [31:0] prod_ff;
   logic signed [SW-1:0] acc_ff, acc_in, final_sum;
   logic              u_end, v_end, m_end;
   logic              pix_we, wgt_we;
   logic [PAW-1:0]    pix_waddr, pix_raddr;
   logic [WAW-1:0]    wgt_waddr, wgt_raddr;

   logic              out_push, out_stat, out_do_pop;
   logic signed [SW-1:0] out_sum;
   logic signed [SW-1:0] out_sum_ff [2];
   logic              out_stat_ff [2];
   logic              out_wp_ff, out_rp_ff;
   logic [1:0]        out_cnt_ff;

   assign u_end = (32'(u_ff) + 32'd1 == 32'(cfg.kernel_width));
   assign v_end = (32'(v_ff) + 32'd1 == 32'(cfg.kernel_height));
   assign m_end = (32'(m_ff) + 32'd1 == 32'(cfg.in_maps));
   assign final_sum = acc_ff + SW'(prod_ff);

   // Write addresses come from the queue head; read addresses from the tap counters.
   always_comb begin
      pix_waddr = PAW'((32'(q_cmd.src_map) * MAX_DIM + 32'(q_cmd.row)) * MAX_DIM
                       + 32'(q_cmd.col));
      wgt_waddr = WAW'(((32'(q_cmd.dst_map) * MAX_IN_MAPS + 32'(q_cmd.src_map)) * MAX_KERNEL
                        + 32'(q_cmd.row)) * MAX_KERNEL + 32'(q_cmd.col));
      pix_raddr = PAW'((32'(m_ff) * MAX_DIM + 32'(job_ff.row) + 32'(v_ff)) * MAX_DIM
                       + 32'(job_ff.col) + 32'(u_ff));
      wgt_raddr = WAW'(((32'(job_ff.dst_map) * MAX_IN_MAPS + 32'(m_ff)) * MAX_KERNEL
                        + 32'(cfg.kernel_height) - 32'd1 - 32'(v_ff)) * MAX_KERNEL
                       + 32'(cfg.kernel_width) - 32'd1 - 32'(u_ff));
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      m_in     = m_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      s1_in    = 1'b0;
      last1_in = 1'b0;
      acc_in   = s2_ff ? final_sum : acc_ff;
      q_pop    = 1'b0;
      pix_we   = 1'b0;
      wgt_we   = 1'b0;
      out_push = 1'b0;
      out_sum  = '0;
      out_stat = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && (out_cnt_ff != 2'd2)) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  cv2d_pkg::KIND_WR_WGT: begin
                     wgt_we   = 1'b1;
                     out_push = 1'b1;
                  end
                  cv2d_pkg::KIND_WR_PIX: begin
                     pix_we   = 1'b1;
                     out_push = 1'b1;
                  end
                  cv2d_pkg::KIND_COMPUTE: begin
                     job_in   = q_cmd;
                     m_in     = '0;
                     u_in     = '0;
                     v_in     = '0;
                     acc_in   = '0;
                     state_in = ST_RUN;
                  end
                  default: begin
                     out_push = 1'b1;
                     out_stat = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            s1_in    = 1'b1;
            last1_in = u_end && v_end && m_end;
            if (!u_end) begin
               u_in = u_ff + 1'b1;
            end else begin
               u_in = '0;
               if (!v_end) begin
                  v_in = v_ff + 1'b1;
               end else begin
                  v_in = '0;
                  m_in = m_ff + 1'b1;
               end
            end
            if (last1_in) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (s2_ff && last2_ff) begin
               out_push = 1'b1;
               out_sum  = final_sum;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
         last1_ff <= 1'b0;
         last2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_ff    <= s1_in;
         s2_ff    <= s1_ff;
         last1_ff <= last1_in;
         last2_ff <= last1_ff;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      m_ff    <= m_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      prod_ff <= w_rd_ff * p_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (pix_we) pix_mem[pix_waddr] <= q_cmd.sample;
      p_rd_ff <= pix_mem[pix_raddr];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem[wgt_waddr] <= q_cmd.sample;
      w_rd_ff <= wgt_mem[wgt_raddr];
   end

   // Result queue.
   assign rsp_empty    = (out_cnt_ff == 2'd0);
   assign out_do_pop   = rsp_pop && !rsp_empty;
   assign rsp_conv_sum = out_sum_ff[out_rp_ff];
   assign rsp_status   = out_stat_ff[out_rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wp_ff  <= 1'b0;
         out_rp_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         out_wp_ff  <= out_wp_ff ^ out_push;
         out_rp_ff  <= out_rp_ff ^ out_do_pop;
         out_cnt_ff <= out_cnt_ff + {1'b0, out_push} - {1'b0, out_do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_sum_ff[out_wp_ff]  <= out_sum;
         out_stat_ff[out_wp_ff] <= out_stat;
      end
   end

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_cnt_ff != 2'd2))
      else $error("result pushed into a full result queue");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("command taken while the engine is busy");

   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      (s2_ff && last2_ff) |-> (state_ff == ST_DRAIN))
      else $error("final product outside drain");

   a_run_leads_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> ($past(state_ff) == ST_RUN || $past(state_ff) == ST_DRAIN))
      else $error("drain entered without running");

endmodule
